[design/pss_pkg.sv]
// Shared types and constants for the packed set swap-remove block.
`default_nettype none

package pss_pkg;

    localparam int unsigned ID_W   = 8;
    localparam int unsigned KEY_W  = ID_W + 1;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned DEPTH  = 1 << KEY_W;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_LOOKUP
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_PRESENT,
        ST_ABSENT,
        ST_FULL
    } status_t;

    typedef struct packed {
        logic [1:0]      op;
        logic            set_sel;
        logic [ID_W-1:0] entity_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  slot;
        logic [ID_W-1:0]  moved_entity;
        logic [CNT_W-1:0] member_count;
    } out_item_t;

    typedef struct packed {
        logic             pres_we;
        logic [KEY_W-1:0] pres_addr;
        logic             pres_data;
        logic             slot_we;
        logic [KEY_W-1:0] slot_addr;
        logic [ID_W-1:0]  slot_data;
        logic             mem_we;
        logic [KEY_W-1:0] mem_addr;
        logic [ID_W-1:0]  mem_data;
    } wr_t;

endpackage

`default_nettype wire

[design/pss_ram.sv]
// Single-port-write, registered-read memory for the set tables.
`default_nettype none

module pss_ram
    import pss_pkg::*;
#(
    parameter int unsigned DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [KEY_W-1:0]  waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [KEY_W-1:0]  raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/packed_set_swap_remove_top.sv]
// Top level of the packed set swap-remove block.
// Two packed sets of 8-bit ids (shown, hidden) with add, swap-remove and lookup.
// Command channel: cmd carries op, set_sel and entity_id; an item is taken at a
// rising edge with cmd_valid high and cmd_stall low.
// Result channel: res carries status, slot, moved_entity and member_count; it is
// taken at a rising edge with res_valid high and res_stall low.
// Path: an item taken waits in the read stage (s1 registers and memory read data);
// once it fires, its result is registered and offered on the result channel.
// Throughput: one item per cycle while res_stall is low; memory reads are issued as an
// item is taken and the write of the previous item is bypassed into the next.
// Reset: counts clear at once; the presence table is then swept, one entry per
// cycle, over all 512 entries with cmd_stall held high.
// While res_stall holds a result, one more item is taken into the read stage and
// waits there; cmd_stall then rises until the result register drains.
// MAX_ENTITIES caps each set at min(MAX_ENTITIES, 256) members.
`default_nettype none

module packed_set_swap_remove_top
    import pss_pkg::*;
#(
    parameter int unsigned MAX_ENTITIES = 256
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire in_item_t  cmd,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res
);

    localparam int unsigned CAP = (MAX_ENTITIES < 256) ? MAX_ENTITIES : 256;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    logic             s1_valid_reg;
    in_item_t         s1_item_reg;
    logic [ID_W-1:0]  s1_last_reg;
    wr_t              fwd_reg;
    logic [CNT_W-1:0] cnt_reg [2];
    logic [CNT_W-1:0] cnt_next [2];
    logic             clr_busy_reg;
    logic [KEY_W-1:0] clr_addr_reg;
    logic             res_valid_reg;
    out_item_t        res_reg;

    logic             accept;
    logic             fire;
    logic [ID_W-1:0]  last_in;
    logic             pres_rd;
    logic [ID_W-1:0]  slot_rd;
    logic [ID_W-1:0]  mem_rd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] last_key;
    logic             here;
    logic [ID_W-1:0]  slot_v;
    logic [ID_W-1:0]  last_id;
    logic [CNT_W-1:0] cnt_cur;
    logic [CNT_W-1:0] cnt_new;
    wr_t              wr;
    wr_t              wr_eff;
    out_item_t        result;
    logic             pres_we;
    logic [KEY_W-1:0] pres_waddr;
    logic             pres_wdata;

    assign fire      = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = clr_busy_reg || (s1_valid_reg && !fire);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign last_in = ID_W'(cnt_next[cmd.set_sel] - CNT_W'(1));

    assign pres_we    = clr_busy_reg ? 1'b1 : wr_eff.pres_we;
    assign pres_waddr = clr_busy_reg ? clr_addr_reg : wr_eff.pres_addr;
    assign pres_wdata = clr_busy_reg ? 1'b0 : wr_eff.pres_data;

    pss_ram #(.DATA_W(1)) u_pres (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .re    (accept),
        .raddr ({cmd.set_sel, cmd.entity_id}),
        .rdata (pres_rd)
    );

    pss_ram #(.DATA_W(ID_W)) u_slot (
        .clk   (clk),
        .we    (wr_eff.slot_we),
        .waddr (wr_eff.slot_addr),
        .wdata (wr_eff.slot_data),
        .re    (accept),
        .raddr ({cmd.set_sel, cmd.entity_id}),
        .rdata (slot_rd)
    );

    pss_ram #(.DATA_W(ID_W)) u_member (
        .clk   (clk),
        .we    (wr_eff.mem_we),
        .waddr (wr_eff.mem_addr),
        .wdata (wr_eff.mem_data),
        .re    (accept),
        .raddr ({cmd.set_sel, last_in}),
        .rdata (mem_rd)
    );

    assign key      = {s1_item_reg.set_sel, s1_item_reg.entity_id};
    assign last_key = {s1_item_reg.set_sel, s1_last_reg};
    assign cnt_cur  = cnt_reg[s1_item_reg.set_sel];

    assign here    = (fwd_reg.pres_we && fwd_reg.pres_addr == key) ? fwd_reg.pres_data
                                                                    : pres_rd;
    assign slot_v  = (fwd_reg.slot_we && fwd_reg.slot_addr == key) ? fwd_reg.slot_data
                                                                    : slot_rd;
    assign last_id = (fwd_reg.mem_we && fwd_reg.mem_addr == last_key) ? fwd_reg.mem_data
                                                                       : mem_rd;

    always_comb
    begin
        result              = '0;
        result.status       = ST_OK;
        cnt_new             = cnt_cur;
        wr                  = '0;
        case (s1_item_reg.op)
            OP_ADD:
            begin
                if (here)
                begin
                    result.status = ST_PRESENT;
                end
                else if (cnt_cur >= CAP_CNT)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    result.slot  = cnt_cur[ID_W-1:0];
                    wr.pres_we   = 1'b1;
                    wr.pres_addr = key;
                    wr.pres_data = 1'b1;
                    wr.slot_we   = 1'b1;
                    wr.slot_addr = key;
                    wr.slot_data = cnt_cur[ID_W-1:0];
                    wr.mem_we    = 1'b1;
                    wr.mem_addr  = {s1_item_reg.set_sel, cnt_cur[ID_W-1:0]};
                    wr.mem_data  = s1_item_reg.entity_id;
                    cnt_new      = cnt_cur + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!here || cnt_cur == '0)
                begin
                    result.status = ST_ABSENT;
                end
                else
                begin
                    result.slot         = slot_v;
                    result.moved_entity = last_id;
                    wr.mem_we           = 1'b1;
                    wr.mem_addr         = {s1_item_reg.set_sel, slot_v};
                    wr.mem_data         = last_id;
                    wr.slot_we          = 1'b1;
                    wr.slot_addr        = {s1_item_reg.set_sel, last_id};
                    wr.slot_data        = slot_v;
                    wr.pres_we          = 1'b1;
                    wr.pres_addr        = key;
                    wr.pres_data        = 1'b0;
                    cnt_new             = cnt_cur - CNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
                if (here)
                begin
                    result.slot = slot_v;
                end
                else
                begin
                    result.status = ST_ABSENT;
                end
            end
            default:
            begin
            end
        endcase
        result.member_count = cnt_new;
    end

    always_comb
    begin
        wr_eff         = wr;
        wr_eff.pres_we = wr.pres_we && fire;
        wr_eff.slot_we = wr.slot_we && fire;
        wr_eff.mem_we  = wr.mem_we && fire;
    end

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            cnt_next[s] = (fire && s1_item_reg.set_sel == 1'(s)) ? cnt_new : cnt_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + KEY_W'(1);
                if (clr_addr_reg == KEY_W'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= wr_eff;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= cmd;
            s1_last_reg <= last_in;
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the packed set swap-remove block.
`timescale 1ns / 100ps

module tb_top;
    import pss_pkg::*;

    localparam int unsigned MAX_ENT     = 256;
    localparam int unsigned SET_CAP     = (MAX_ENT < 256) ? MAX_ENT : 256;
    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 60000;

    class packed_set_scoreboard;
        bit          present [2][256];
        logic [7:0]  slot_of [2][256];
        logic [7:0]  members [2][256];
        logic [8:0]  count [2];
        out_item_t   awaited_results [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned commands;
        int unsigned status_seen [4];
        int unsigned peak_count;

        function new();
            foreach (present[s, i])
            begin
                present[s][i] = 1'b0;
                slot_of[s][i] = '0;
                members[s][i] = '0;
            end
            count[0] = '0;
            count[1] = '0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            errors = 0;
            checked = 0;
            commands = 0;
            peak_count = 0;
        endfunction

        // Advance the set state by one command and return its result.
        function out_item_t apply_command(in_item_t c);
            out_item_t  r;
            status_t    st;
            logic [7:0] slot;
            logic [7:0] moved;
            logic [7:0] idx;
            logic [7:0] last_id;
            logic [8:0] cnt;
            int         s;
            bit         here;
            s = int'(c.set_sel);
            st = ST_OK;
            slot = '0;
            moved = '0;
            cnt = count[s];
            here = present[s][c.entity_id];
            case (c.op)
                OP_ADD:
                begin
                    if (here)
                        st = ST_PRESENT;
                    else if (cnt >= SET_CAP)
                        st = ST_FULL;
                    else
                    begin
                        slot = cnt[7:0];
                        slot_of[s][c.entity_id] = slot;
                        members[s][slot] = c.entity_id;
                        present[s][c.entity_id] = 1'b1;
                        cnt = cnt + 9'd1;
                    end
                end
                OP_REMOVE:
                begin
                    if (!here || cnt == 0)
                        st = ST_ABSENT;
                    else
                    begin
                        idx = slot_of[s][c.entity_id];
                        last_id = members[s][cnt[7:0] - 8'd1];
                        members[s][idx] = last_id;
                        slot_of[s][last_id] = idx;
                        present[s][c.entity_id] = 1'b0;
                        cnt = cnt - 9'd1;
                        slot = idx;
                        moved = last_id;
                    end
                end
                OP_LOOKUP:
                begin
                    if (here)
                        slot = slot_of[s][c.entity_id];
                    else
                        st = ST_ABSENT;
                end
                default:
                    ;
            endcase
            count[s] = cnt;
            if (cnt > peak_count)
                peak_count = 32'(cnt);
            r.status = st;
            r.slot = slot;
            r.moved_entity = moved;
            r.member_count = cnt;
            return r;
        endfunction

        function void note_command(in_item_t c);
            out_item_t r;
            r = apply_command(c);
            status_seen[r.status]++;
            commands++;
            awaited_results.push_back(r);
        endfunction

        function void compare(string field, logic [8:0] want, logic [8:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            compare("status", 9'(want.status), 9'(got.status));
            compare("slot", 9'(want.slot), 9'(got.slot));
            compare("moved_entity", 9'(want.moved_entity), 9'(got.moved_entity));
            compare("member_count", want.member_count, got.member_count);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_item_t  cmd;
    logic      res_valid;
    logic      res_stall;
    out_item_t res;
    bit        calm;

    packed_set_scoreboard board;

    packed_set_swap_remove_top #(
        .MAX_ENTITIES (MAX_ENT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    function automatic in_item_t mk(logic [1:0] op, logic sel, logic [7:0] id);
        in_item_t it;
        it.op = op;
        it.set_sel = sel;
        it.entity_id = id;
        return it;
    endfunction

    // Mix of operations; removes and lookups mostly aim at current members.
    function automatic in_item_t random_item(bit wide_ids, int add_pct);
        in_item_t it;
        int       r;
        int       s;
        r = $urandom_range(99);
        s = $urandom_range(1);
        it.set_sel = 1'(s);
        if (r >= 96)
            it.op = OP_NOP;
        else if (r < add_pct)
            it.op = OP_ADD;
        else if (r < add_pct + (96 - add_pct) * 6 / 10)
            it.op = OP_REMOVE;
        else
            it.op = OP_LOOKUP;
        it.entity_id = wide_ids ? 8'($urandom_range(255)) : 8'($urandom_range(15));
        if ((it.op == OP_REMOVE || it.op == OP_LOOKUP) && board.count[s] != 0
            && $urandom_range(99) < 60)
            it.entity_id = board.members[s][$urandom_range(board.count[s] - 1)];
        return it;
    endfunction

    // Add an absent id to the hidden set.
    function automatic in_item_t fill_item();
        logic [7:0] id;
        id = 8'($urandom_range(255));
        for (int i = 0; i < 256 && board.present[1][id]; i++)
            id = id + 8'd1;
        return mk(OP_ADD, 1'b1, id);
    endfunction

    task automatic send_item(input in_item_t it);
        while (!calm && $urandom_range(99) < 9)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= it;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_command(it);
    endtask

    initial
    begin : result_side
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid === 1'b1 && !res_stall)
                board.check_result(res);
            if (!hold_done && board.checked >= 150)
            begin
                hold_done = 1'b1;
                hold_left = 90;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= (!calm && $urandom_range(99) < 9);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("** packed_set_swap_remove_top: FAILED **");
        $finish;
    end

    initial
    begin : command_side
        board = new();
        calm = 1'b0;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        send_item(mk(OP_LOOKUP, 1'b0, 8'h00));
        send_item(mk(OP_REMOVE, 1'b0, 8'hFF));
        send_item(mk(OP_ADD, 1'b0, 8'h00));
        send_item(mk(OP_ADD, 1'b0, 8'hFF));
        send_item(mk(OP_ADD, 1'b0, 8'h00));
        send_item(mk(OP_ADD, 1'b0, 8'h80));
        send_item(mk(OP_ADD, 1'b0, 8'h7F));
        send_item(mk(OP_LOOKUP, 1'b0, 8'hFF));
        send_item(mk(OP_LOOKUP, 1'b1, 8'hFF));
        send_item(mk(OP_REMOVE, 1'b0, 8'h00));
        send_item(mk(OP_LOOKUP, 1'b0, 8'h7F));
        send_item(mk(OP_REMOVE, 1'b0, 8'h80));
        send_item(mk(OP_NOP, 1'b0, 8'h55));
        send_item(mk(OP_NOP, 1'b1, 8'hAA));
        send_item(mk(OP_ADD, 1'b1, 8'hFF));
        send_item(mk(OP_REMOVE, 1'b1, 8'hFF));
        send_item(mk(OP_REMOVE, 1'b1, 8'hFF));
        send_item(mk(OP_ADD, 1'b1, 8'h01));
        send_item(mk(OP_LOOKUP, 1'b1, 8'h01));
        send_item(mk(OP_REMOVE, 1'b0, 8'hFF));
        send_item(mk(OP_REMOVE, 1'b0, 8'h7F));
        send_item(mk(OP_ADD, 1'b0, 8'h7F));

        for (int i = 0; i < 180; i++)
        begin
            calm = (i >= 40 && i < 110);
            send_item(random_item(1'b0, 45));
        end
        calm = 1'b0;

        while (board.count[1] < SET_CAP)
        begin
            if ($urandom_range(99) < 15)
                send_item(random_item(1'b1, 40));
            else
                send_item(fill_item());
        end
        for (int i = 0; i < 12; i++)
            send_item(mk(OP_ADD, 1'b1, 8'($urandom_range(255))));

        for (int i = 0; i < 140; i++)
            send_item(random_item(1'b1, 15));

        cmd_valid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        $display("Sent %0d items over both sets, %0d results checked, peak set size %0d.",
                 board.commands, board.checked, board.peak_count);
        $display("Statuses: ok %0d, already present %0d, not present %0d, set full %0d.",
                 board.status_seen[ST_OK], board.status_seen[ST_PRESENT],
                 board.status_seen[ST_ABSENT], board.status_seen[ST_FULL]);
        if (board.errors == 0 && board.awaited_results.size() == 0)
            $display("** packed_set_swap_remove_top: PASSED **");
        else
            $display("** packed_set_swap_remove_top: FAILED **");
        $finish;
    end

endmodule
